>>> rtl/dvfc_pkg.sv
package dvfc_pkg;

  // Table capacity and field widths.
  localparam int MAX_ITEMS  = 32;
  localparam int VALUE_BITS = 16;
  localparam int COUNT_W    = 6;
  localparam int ITEM_W     = $clog2(MAX_ITEMS + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  // Input transaction payload.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         end_of_set;
  } item_t;

  // Output transaction payload.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] distinct_value;
    logic [COUNT_W-1:0]           occurrences;
    logic                         last_entry;
    logic                         overflow;
  } result_t;

  // Contents of one table cell.
  typedef struct packed {
    logic                         valid;
    logic signed [VALUE_BITS-1:0] value;
    logic [COUNT_W-1:0]           count;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic take;
    logic shift;
    logic any_hit;
  } cell_ctrl_t;

endpackage

>>> rtl/dvfc_cell.sv
module dvfc_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dvfc_pkg::cell_ctrl_t                  ctrl,
  input  logic signed [dvfc_pkg::VALUE_BITS-1:0] value,
  input  logic                                  prev_valid,
  input  dvfc_pkg::entry_t                      nbr,
  output dvfc_pkg::entry_t                      entry,
  output logic                                  hit
);

  logic append;

  // A cell matches when it holds the broadcast value.
  assign hit = entry.valid && (entry.value == value);

  // The first empty cell takes a value that no cell holds yet.
  assign append = !entry.valid && prev_valid && !ctrl.any_hit;

  // During emission the cell takes its neighbor's contents; otherwise it
  // counts or appends the broadcast value.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctrl.shift) begin
      entry <= nbr;
    end else if (ctrl.take) begin
      if (hit) begin
        if (entry.count != dvfc_pkg::COUNT_MAX) begin
          entry.count <= entry.count + dvfc_pkg::COUNT_ONE;
        end
      end else if (append) begin
        entry.valid <= 1'b1;
        entry.value <= value;
        entry.count <= dvfc_pkg::COUNT_ONE;
      end
    end
  end

endmodule

>>> rtl/distinct_value_frequency_count_core.sv
// Counts the distinct values of a set in a row of 32 cells. For each item,
// all cells compare the value at once, and the matching cell counts it or
// the first empty cell appends it. After the item marked end_of_set the
// table shifts out through cell 0 at one result per cycle while the output
// does not stall, in order of first appearance, and no item is taken until
// the result with last_entry has been transferred. Items beyond 32 in one
// set are dropped and raise overflow on every result of that set.
module distinct_value_frequency_count_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dvfc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output dvfc_pkg::result_t result
);

  typedef enum logic {ST_COLLECT, ST_EMIT} state_t;

  state_t                          state;
  logic [dvfc_pkg::ITEM_W-1:0]     items_taken;
  logic                            dropped;
  logic                            item_take;
  logic                            result_take;
  logic                            room;
  dvfc_pkg::cell_ctrl_t            ctrl;
  dvfc_pkg::entry_t                ent [dvfc_pkg::MAX_ITEMS];
  logic [dvfc_pkg::MAX_ITEMS-1:0]  hits;
  logic [dvfc_pkg::MAX_ITEMS-1:0]  valid_vec;

  // Handshake decode.
  assign item_stall  = (state == ST_EMIT);
  assign item_take   = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;
  assign room        = items_taken < dvfc_pkg::ITEM_W'(dvfc_pkg::MAX_ITEMS);

  // Control broadcast to the cells.
  assign ctrl.take    = item_take && room;
  assign ctrl.shift   = result_take;
  assign ctrl.any_hit = |hits;

  // The row of cells; cell 0 holds the oldest entry and feeds the output.
  for (genvar i = 0; i < dvfc_pkg::MAX_ITEMS; i++) begin : g_cell
    dvfc_pkg::entry_t nbr;
    logic             prev_valid;

    if (i == dvfc_pkg::MAX_ITEMS - 1) begin : g_end
      always_comb begin
        nbr       = ent[i];
        nbr.valid = 1'b0;
      end
    end else begin : g_mid
      assign nbr = ent[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_tail
      assign prev_valid = ent[i-1].valid;
    end

    dvfc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (item.value),
      .prev_valid (prev_valid),
      .nbr        (nbr),
      .entry      (ent[i]),
      .hit        (hits[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  // Output transaction straight from cell 0.
  assign result_valid          = (state == ST_EMIT) && ent[0].valid;
  assign result.distinct_value = ent[0].value;
  assign result.occurrences    = ent[0].count;
  assign result.last_entry     = (dvfc_pkg::MAX_ITEMS == 1) ? 1'b1 : !valid_vec[1];
  assign result.overflow       = dropped;

  // Sequencer: collect a set, then drain the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_COLLECT;
      items_taken <= '0;
      dropped     <= 1'b0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          if (item_take) begin
            if (room) begin
              items_taken <= items_taken + dvfc_pkg::ITEM_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (item.end_of_set) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!ent[0].valid || (result_take && result.last_entry)) begin
            state       <= ST_COLLECT;
            items_taken <= '0;
            dropped     <= 1'b0;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  // No item is taken while results are pending.
  a_stall_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item accepted during emission");

  // Occupied cells always form a contiguous run starting at cell 0.
  a_contig: assert property (@(posedge clk) disable iff (rst)
    $onehot0({1'b0, valid_vec} + {{dvfc_pkg::MAX_ITEMS{1'b0}}, 1'b1}))
    else $error("table has a gap");

  // The table is empty after its final entry is transferred.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (result_take && result.last_entry) |=> (valid_vec == '0))
    else $error("table not empty after last entry");

  // Item count never exceeds capacity.
  a_items: assert property (@(posedge clk) disable iff (rst)
    items_taken <= dvfc_pkg::ITEM_W'(dvfc_pkg::MAX_ITEMS))
    else $error("item count beyond capacity");

endmodule

>>> tb/sv/distinct_value_frequency_count_core_test.sv
`timescale 1ns / 100ps

module distinct_value_frequency_count_core_test;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  dvfc_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  dvfc_pkg::result_t result;

  // When set, neither side idles or stalls.
  logic quiet = 1'b0;

  // Shadow of the count table, updated on every accepted input transaction.
  logic signed [dvfc_pkg::VALUE_BITS-1:0] tally_value [dvfc_pkg::MAX_ITEMS];
  logic [dvfc_pkg::COUNT_W-1:0]           tally_count [dvfc_pkg::MAX_ITEMS];
  int                                     tally_used = 0;
  int                                     tally_taken = 0;
  logic                                   tally_dropped = 1'b0;

  // Results predicted but not yet seen on the output.
  dvfc_pkg::result_t due_results [$];
  int                mismatch_count = 0;

  distinct_value_frequency_count_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #500_000;
    $display("end of test: mismatches");
    $finish;
  end

  // The output side stalls now and then, except in a quiet stretch.
  always @(posedge clk) begin
    result_stall <= !quiet && ($urandom_range(99) < 8);
  end

  // Returns a random value of the input width.
  function automatic logic signed [dvfc_pkg::VALUE_BITS-1:0] rand_value();
    logic [31:0] raw;
    raw = $urandom;
    return raw[dvfc_pkg::VALUE_BITS-1:0];
  endfunction

  // Counts one value into the shadow table and, at the end of a set,
  // queues the whole table as expected results and clears it.
  function automatic void tally_item(dvfc_pkg::item_t it);
    int                hit;
    dvfc_pkg::result_t r;
    hit = -1;
    if (tally_taken >= dvfc_pkg::MAX_ITEMS) begin
      tally_dropped = 1'b1;
    end else begin
      tally_taken++;
      for (int i = 0; i < tally_used; i++) begin
        if (hit < 0 && tally_value[i] == it.value) hit = i;
      end
      if (hit >= 0) begin
        if (tally_count[hit] != dvfc_pkg::COUNT_MAX) tally_count[hit]++;
      end else if (tally_used < dvfc_pkg::MAX_ITEMS) begin
        tally_value[tally_used] = it.value;
        tally_count[tally_used] = dvfc_pkg::COUNT_ONE;
        tally_used++;
      end
    end
    if (it.end_of_set) begin
      for (int i = 0; i < tally_used; i++) begin
        r.distinct_value = tally_value[i];
        r.occurrences    = tally_count[i];
        r.last_entry     = (i == tally_used - 1);
        r.overflow       = tally_dropped;
        due_results.push_back(r);
      end
      tally_used    = 0;
      tally_taken   = 0;
      tally_dropped = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    if (mismatch_count < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    mismatch_count++;
  endfunction

  // Compares one output transaction with the oldest expectation.
  function automatic void check_result(dvfc_pkg::result_t got);
    dvfc_pkg::result_t want;
    if (due_results.size() == 0) begin
      note_mismatch("unexpected result, value", '0, got.distinct_value);
    end else begin
      want = due_results.pop_front();
      if (want.distinct_value !== got.distinct_value)
        note_mismatch("distinct_value", want.distinct_value, got.distinct_value);
      if (want.occurrences !== got.occurrences)
        note_mismatch("occurrences", 16'(want.occurrences), 16'(got.occurrences));
      if (want.last_entry !== got.last_entry)
        note_mismatch("last_entry", 16'(want.last_entry), 16'(got.last_entry));
      if (want.overflow !== got.overflow)
        note_mismatch("overflow", 16'(want.overflow), 16'(got.overflow));
    end
  endfunction

  // Watches both channels. An output transaction at an edge never belongs to
  // an input taken at that same edge, so it is checked first.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) check_result(result);
      if (item_valid && !item_stall) tally_item(item);
    end
  end

  // Sends one input transaction, with an occasional idle gap ahead of it.
  task automatic send_item(input logic signed [dvfc_pkg::VALUE_BITS-1:0] v,
                           input logic eos);
    while (!quiet && $urandom_range(99) < 8) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= dvfc_pkg::item_t'{value: v, end_of_set: eos};
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Extreme values, with repeats, in one set.
  task automatic test_extreme_values();
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(16'sd0, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(-16'sd32768, 1'b1);
  endtask

  // Sets of one item each.
  task automatic test_single_item_sets();
    send_item(16'sd32767, 1'b1);
    send_item(-16'sd32768, 1'b1);
    send_item(16'sd0, 1'b1);
  endtask

  // Short sets with a repeated value, the last item being a repeat.
  task automatic test_repeats();
    send_item(16'sd5, 1'b0);
    send_item(16'sd5, 1'b0);
    send_item(16'sd5, 1'b0);
    send_item(16'sd5, 1'b1);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd7, 1'b0);
    send_item(16'sd7, 1'b1);
  endtask

  // A full table of distinct random values, then one value filling the set.
  task automatic test_full_table();
    logic signed [dvfc_pkg::VALUE_BITS-1:0] seen [$];
    logic signed [dvfc_pkg::VALUE_BITS-1:0] v;
    logic                                   fresh;
    for (int i = 0; i < dvfc_pkg::MAX_ITEMS; i++) begin
      do begin
        v = rand_value();
        fresh = 1'b1;
        foreach (seen[k]) if (seen[k] == v) fresh = 1'b0;
      end while (!fresh);
      seen.push_back(v);
      send_item(v, i == dvfc_pkg::MAX_ITEMS - 1);
    end
    v = rand_value();
    for (int i = 0; i < dvfc_pkg::MAX_ITEMS; i++) send_item(v, i == dvfc_pkg::MAX_ITEMS - 1);
  endtask

  // Sends a set whose values come partly from a small pool, partly at random.
  task automatic send_random_set(input int len);
    logic signed [dvfc_pkg::VALUE_BITS-1:0] pool [4];
    logic signed [dvfc_pkg::VALUE_BITS-1:0] v;
    foreach (pool[k]) pool[k] = rand_value();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1) == 1) v = pool[$urandom_range(3)];
      else v = rand_value();
      send_item(v, i == len - 1);
    end
  endtask

  // Sets longer than the table, so the end mark lands on a dropped item.
  task automatic test_capacity_overflow();
    send_random_set(dvfc_pkg::MAX_ITEMS + 1);
    send_random_set(dvfc_pkg::MAX_ITEMS + 3);
    send_random_set(dvfc_pkg::MAX_ITEMS + $urandom_range(1, 8));
  endtask

  // Random sets of mixed length, with a stretch without idling or stalls.
  task automatic test_random_sets();
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < 180) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(1, 10);
      else if (r < 88) len = $urandom_range(11, dvfc_pkg::MAX_ITEMS - 1);
      else if (r < 94) len = dvfc_pkg::MAX_ITEMS;
      else len = $urandom_range(dvfc_pkg::MAX_ITEMS + 1, dvfc_pkg::MAX_ITEMS + 8);
      quiet <= (sent >= 80 && sent < 140);
      send_random_set(len);
      sent += len;
    end
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_values();
    test_single_item_sets();
    test_repeats();
    test_full_table();
    test_capacity_overflow();
    test_random_sets();

    // Drain the outstanding results, then watch for anything extra.
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    // Expected results that never appeared count as a mismatch.
    if (due_results.size() != 0)
      note_mismatch("missing results, count", '0, 16'(due_results.size()));

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
